// ===== rtl/assert_macros.svh =====
// Assertion macros for RTL that checks its own behavior.
// Depends on nothing; included by the top level of the sphere mesh generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define USMG_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define USMG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/usmg_pkg.sv =====
// Shared types, codes and constants of the UV sphere mesh generator.
// Depends on nothing; used by the controller, datapath and top level.
package usmg_pkg;

   localparam int COUNT_W      = 11;
   localparam int RADIUS_W     = 24;
   localparam int CSR_DATA_W   = 24;
   localparam int CSR_INDEX_W  = 2;
   localparam int WORD_W       = 32;
   localparam int HALF_W       = 16;
   localparam int INDEX_W      = 2 * COUNT_W + 1;
   localparam int ATAN_ENTRIES = 24;

   localparam int MAX_DIVISIONS_DEFAULT = 1024;
   localparam int TRIG_STEPS_DEFAULT    = 16;

   // CORDIC start vector length, compensating the gain, in Q2.30.
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLICES = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STACKS = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_VERTEX   = 2'd0;
   localparam logic [1:0] KIND_TRIANGLE = 2'd1;
   localparam logic [1:0] KIND_FINISHED = 2'd2;

   typedef enum logic [1:0] {
      PHASE_VERTEX,
      PHASE_TRIANGLE,
      PHASE_DONE
   } phase_type;

   typedef enum logic [3:0] {
      ST_SETUP_INIT,
      ST_SETUP_RUN,
      ST_IDLE,
      ST_TH_LOAD,
      ST_TH_RUN,
      ST_PH_LOAD,
      ST_PH_RUN,
      ST_PH_SAVE,
      ST_MUL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic restart;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]               kind;
      logic signed [WORD_W-1:0] word_a;
      logic signed [WORD_W-1:0] word_b;
      logic signed [WORD_W-1:0] word_c;
      logic signed [HALF_W-1:0] normal_x;
      logic signed [HALF_W-1:0] normal_y;
      logic signed [HALF_W-1:0] normal_z;
      logic [HALF_W-1:0]        tex_s;
      logic [HALF_W-1:0]        tex_t;
      logic                     last;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic seq_restart;
      logic div_init;
      logic div_step;
      logic cordic_load;
      logic cordic_sel_phi;
      logic cordic_step;
      logic save_theta;
      logic save_phi;
      logic mul_init;
      logic mul_run;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_last;
      logic cordic_last;
      logic mul_last;
      logic rsp_free;
      logic vertex_phase;
   } status_type;

   // Arctangent of 2^-k as a fraction of a full turn, 2^32 per turn.
   function automatic logic [31:0] atan_turn(input logic [4:0] k);
      logic [31:0] a;
      case (k)
         5'd0:    a = 32'h20000000;
         5'd1:    a = 32'h12E4051E;
         5'd2:    a = 32'h09FB385B;
         5'd3:    a = 32'h051111D4;
         5'd4:    a = 32'h028B0D43;
         5'd5:    a = 32'h0145D7E1;
         5'd6:    a = 32'h00A2F61E;
         5'd7:    a = 32'h00517C55;
         5'd8:    a = 32'h0028BE53;
         5'd9:    a = 32'h00145F2F;
         5'd10:   a = 32'h000A2F98;
         5'd11:   a = 32'h000517CC;
         5'd12:   a = 32'h00028BE6;
         5'd13:   a = 32'h000145F3;
         5'd14:   a = 32'h0000A2FA;
         5'd15:   a = 32'h0000517D;
         5'd16:   a = 32'h000028BE;
         5'd17:   a = 32'h0000145F;
         5'd18:   a = 32'h00000A30;
         5'd19:   a = 32'h00000518;
         5'd20:   a = 32'h0000028C;
         5'd21:   a = 32'h00000146;
         5'd22:   a = 32'h000000A3;
         5'd23:   a = 32'h00000051;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

// ===== rtl/usmg_stream_if.sv =====
// Valid/ready stream interface carrying one payload per transaction.
// Depends on nothing itself; the payload type, such as those of usmg_pkg, is chosen where it is instantiated.
interface usmg_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/usmg_ctrl.sv =====
// Controller state machine of the sphere mesh generator: sequences setup,
// the two CORDIC passes, the multiplies and the result hand-off. Uses usmg_pkg.
module usmg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_restart,
   output logic                 req_ready,
   input  logic                 csr_write_en,
   input  logic [usmg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  usmg_pkg::status_type status,
   output usmg_pkg::cmd_type    cmd
);
   import usmg_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      csr_known;
   logic      accept;

   assign csr_known = csr_write_en &&
                      (csr_index == CSR_RADIUS || csr_index == CSR_SLICES ||
                       csr_index == CSR_STACKS);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SETUP_INIT: state_in = ST_SETUP_RUN;
         ST_SETUP_RUN: begin
            if (status.div_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_restart || status.vertex_phase) ? ST_TH_LOAD : ST_EMIT;
            end
         end
         ST_TH_LOAD: state_in = ST_TH_RUN;
         ST_TH_RUN: begin
            if (status.cordic_last) state_in = ST_PH_LOAD;
         end
         ST_PH_LOAD: state_in = ST_PH_RUN;
         ST_PH_RUN: begin
            if (status.cordic_last) state_in = ST_PH_SAVE;
         end
         ST_PH_SAVE: state_in = ST_MUL;
         ST_MUL: begin
            if (status.mul_last) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_SETUP_INIT;
      endcase
      // A register write may change the counts, so the step constants are rebuilt.
      if (csr_known) state_in = ST_SETUP_INIT;
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_SETUP_INIT: begin
            cmd.seq_restart = 1'b1;
            cmd.div_init    = 1'b1;
         end
         ST_SETUP_RUN: cmd.div_step = 1'b1;
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.seq_restart = accept && req_restart;
         end
         ST_TH_LOAD: cmd.cordic_load = 1'b1;
         ST_TH_RUN:  cmd.cordic_step = 1'b1;
         ST_PH_LOAD: begin
            cmd.save_theta     = 1'b1;
            cmd.cordic_load    = 1'b1;
            cmd.cordic_sel_phi = 1'b1;
         end
         ST_PH_RUN: cmd.cordic_step = 1'b1;
         ST_PH_SAVE: begin
            cmd.save_phi = 1'b1;
            cmd.mul_init = 1'b1;
         end
         ST_MUL:  cmd.mul_run = 1'b1;
         ST_EMIT: cmd.emit    = status.rsp_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SETUP_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/usmg_dp.sv =====
// Datapath of the sphere mesh generator: configuration registers, step
// divider, angle accumulators, CORDIC unit, multiplier and result register.
// Uses usmg_pkg and usmg_stream_if.
module usmg_dp #(
   parameter int MAX_DIVISIONS = usmg_pkg::MAX_DIVISIONS_DEFAULT,
   parameter int TRIG_STEPS    = usmg_pkg::TRIG_STEPS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [usmg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [usmg_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  usmg_pkg::cmd_type    cmd,
   output usmg_pkg::status_type status,
   usmg_stream_if.source        rsp_chan
);
   import usmg_pkg::*;

   localparam int K_W       = $clog2(TRIG_STEPS);
   localparam int DIV_LANES = 4;
   localparam int DIV_W     = 33;
   localparam int DIV_CNT_W = 6;

   // Multiplier slot codes.
   localparam logic [2:0] MUL_NX   = 3'd0;
   localparam logic [2:0] MUL_NY   = 3'd1;
   localparam logic [2:0] MUL_PX   = 3'd2;
   localparam logic [2:0] MUL_PY   = 3'd3;
   localparam logic [2:0] MUL_PZ   = 3'd4;
   localparam logic [2:0] MUL_DONE = 3'd5;

   // Clamp a count to its legal range.
   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                      input logic [COUNT_W-1:0] lo);
      logic [COUNT_W-1:0] r;
      if (v < lo) r = lo;
      else if (32'(v) > 32'(MAX_DIVISIONS)) r = COUNT_W'(MAX_DIVISIONS);
      else r = v;
      return r;
   endfunction

   // Advance a quotient/remainder pair by a fixed quotient/remainder step.
   function automatic logic [WORD_W+COUNT_W-1:0] frac_step(
      input logic [WORD_W-1:0]  q,
      input logic [COUNT_W-1:0] r,
      input logic [WORD_W-1:0]  dq,
      input logic [COUNT_W-1:0] dr,
      input logic [COUNT_W-1:0] d);
      logic [COUNT_W:0]   s;
      logic [WORD_W-1:0]  qn;
      logic [COUNT_W-1:0] rn;
      s = {1'b0, r} + {1'b0, dr};
      if (s >= {1'b0, d}) begin
         rn = COUNT_W'(s - {1'b0, d});
         qn = q + dq + WORD_W'(1);
      end else begin
         rn = s[COUNT_W-1:0];
         qn = q + dq;
      end
      return {qn, rn};
   endfunction

   // Round a Q2.30 value to Q1.15 and saturate.
   function automatic logic signed [HALF_W-1:0] q15_sat(input logic signed [WORD_W-1:0] n);
      logic signed [WORD_W:0] t;
      logic signed [HALF_W-1:0] r;
      t = ($signed({n[WORD_W-1], n}) + 33'sd16384) >>> 15;
      if (t > 33'sd32767) r = 16'sh7FFF;
      else if (t < -33'sd32768) r = 16'sh8000;
      else r = t[HALF_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Configuration registers.
   logic [RADIUS_W-1:0] radius_ff;
   logic [COUNT_W-1:0]  slices_ff;
   logic [COUNT_W-1:0]  stacks_ff;
   logic [COUNT_W-1:0]  s_cnt;
   logic [COUNT_W-1:0]  t_cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_W'(65536);
         slices_ff <= COUNT_W'(16);
         stacks_ff <= COUNT_W'(8);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_RADIUS: radius_ff <= csr_wdata[RADIUS_W-1:0];
            CSR_SLICES: slices_ff <= csr_wdata[COUNT_W-1:0];
            CSR_STACKS: stacks_ff <= csr_wdata[COUNT_W-1:0];
            default:    radius_ff <= radius_ff;
         endcase
      end
   end

   assign s_cnt = clamp_count(slices_ff, COUNT_W'(3));
   assign t_cnt = clamp_count(stacks_ff, COUNT_W'(2));

   // ---------------------------------------------------------------
   // Step divider: four restoring lanes, one quotient bit a cycle, giving
   // 2^32/S, 2^15/S, 2^31/T and 2^15/T.
   logic [COUNT_W:0]       div_rem_ff [DIV_LANES];
   logic [DIV_W-1:0]       div_quo_ff [DIV_LANES];
   logic [COUNT_W:0]       div_rem_in [DIV_LANES];
   logic [DIV_W-1:0]       div_quo_in [DIV_LANES];
   logic [DIV_CNT_W-1:0]   div_cnt_ff;
   logic [DIV_CNT_W-1:0]   lane_exp   [DIV_LANES];
   logic [COUNT_W-1:0]     lane_div   [DIV_LANES];

   assign lane_exp[0] = DIV_CNT_W'(32);
   assign lane_exp[1] = DIV_CNT_W'(15);
   assign lane_exp[2] = DIV_CNT_W'(31);
   assign lane_exp[3] = DIV_CNT_W'(15);
   assign lane_div[0] = s_cnt;
   assign lane_div[1] = s_cnt;
   assign lane_div[2] = t_cnt;
   assign lane_div[3] = t_cnt;

   always_comb begin
      logic [COUNT_W:0] sh;
      for (int n = 0; n < DIV_LANES; n++) begin
         sh = {div_rem_ff[n][COUNT_W-1:0], (div_cnt_ff == lane_exp[n])};
         if (sh >= {1'b0, lane_div[n]}) begin
            div_rem_in[n] = sh - {1'b0, lane_div[n]};
            div_quo_in[n] = {div_quo_ff[n][DIV_W-2:0], 1'b1};
         end else begin
            div_rem_in[n] = sh;
            div_quo_in[n] = {div_quo_ff[n][DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         div_cnt_ff <= DIV_CNT_W'(DIV_W - 1);
         for (int n = 0; n < DIV_LANES; n++) begin
            div_rem_ff[n] <= '0;
            div_quo_ff[n] <= '0;
         end
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
         for (int n = 0; n < DIV_LANES; n++) begin
            div_rem_ff[n] <= div_rem_in[n];
            div_quo_ff[n] <= div_quo_in[n];
         end
      end
   end

   assign status.div_last = (div_cnt_ff == '0);

   // ---------------------------------------------------------------
   // Sequence state and angle accumulators.
   phase_type           phase_ff,    phase_in;
   logic [COUNT_W-1:0]  slice_ff,    slice_in;
   logic [COUNT_W-1:0]  stack_ff,    stack_in;
   logic                second_ff,   second_in;
   logic [WORD_W-1:0]   theta_q_ff,  theta_q_in;
   logic [COUNT_W-1:0]  theta_r_ff,  theta_r_in;
   logic [WORD_W-1:0]   phi_q_ff,    phi_q_in;
   logic [COUNT_W-1:0]  phi_r_ff,    phi_r_in;
   logic [HALF_W-1:0]   texs_q_ff,   texs_q_in;
   logic [COUNT_W-1:0]  texs_r_ff,   texs_r_in;
   logic [HALF_W-1:0]   text_q_ff,   text_q_in;
   logic [COUNT_W-1:0]  text_r_ff,   text_r_in;
   logic [INDEX_W-1:0]  base_ff,     base_in;

   logic [COUNT_W:0]    slice_next;
   logic [COUNT_W:0]    stack_next;
   logic [INDEX_W-1:0]  row_len;
   logic                middle;
   logic [WORD_W+COUNT_W-1:0] th_adv, ph_adv, ts_adv, tt_adv;

   assign slice_next = {1'b0, slice_ff} + (COUNT_W+1)'(1);
   assign stack_next = {1'b0, stack_ff} + (COUNT_W+1)'(1);
   assign row_len    = INDEX_W'(t_cnt) + INDEX_W'(1);
   assign middle     = (stack_ff != '0) && (stack_ff != t_cnt - COUNT_W'(1));

   assign th_adv = frac_step(theta_q_ff, theta_r_ff, div_quo_ff[0][WORD_W-1:0],
                             div_rem_ff[0][COUNT_W-1:0], s_cnt);
   assign ts_adv = frac_step(WORD_W'(texs_q_ff), texs_r_ff, div_quo_ff[1][WORD_W-1:0],
                             div_rem_ff[1][COUNT_W-1:0], s_cnt);
   assign ph_adv = frac_step(phi_q_ff, phi_r_ff, div_quo_ff[2][WORD_W-1:0],
                             div_rem_ff[2][COUNT_W-1:0], t_cnt);
   assign tt_adv = frac_step(WORD_W'(text_q_ff), text_r_ff, div_quo_ff[3][WORD_W-1:0],
                             div_rem_ff[3][COUNT_W-1:0], t_cnt);

   always_comb begin
      phase_in   = phase_ff;
      slice_in   = slice_ff;
      stack_in   = stack_ff;
      second_in  = second_ff;
      theta_q_in = theta_q_ff;
      theta_r_in = theta_r_ff;
      phi_q_in   = phi_q_ff;
      phi_r_in   = phi_r_ff;
      texs_q_in  = texs_q_ff;
      texs_r_in  = texs_r_ff;
      text_q_in  = text_q_ff;
      text_r_in  = text_r_ff;
      base_in    = base_ff;
      if (cmd.seq_restart) begin
         // Back to the first vertex; each accumulator starts at half its divisor.
         phase_in   = PHASE_VERTEX;
         slice_in   = '0;
         stack_in   = '0;
         second_in  = 1'b0;
         theta_q_in = '0;
         theta_r_in = s_cnt >> 1;
         texs_q_in  = '0;
         texs_r_in  = s_cnt >> 1;
         phi_q_in   = '0;
         phi_r_in   = t_cnt >> 1;
         text_q_in  = '0;
         text_r_in  = t_cnt >> 1;
         base_in    = '0;
      end else if (cmd.emit) begin
         case (phase_ff)
            PHASE_VERTEX: begin
               if (stack_next > {1'b0, t_cnt}) begin
                  // Next slice: stack angle restarts, slice angle steps.
                  stack_in   = '0;
                  phi_q_in   = '0;
                  phi_r_in   = t_cnt >> 1;
                  text_q_in  = '0;
                  text_r_in  = t_cnt >> 1;
                  theta_q_in = th_adv[WORD_W+COUNT_W-1:COUNT_W];
                  theta_r_in = th_adv[COUNT_W-1:0];
                  texs_q_in  = ts_adv[COUNT_W+HALF_W-1:COUNT_W];
                  texs_r_in  = ts_adv[COUNT_W-1:0];
                  if (slice_next > {1'b0, s_cnt}) begin
                     slice_in  = '0;
                     phase_in  = PHASE_TRIANGLE;
                     base_in   = '0;
                     second_in = 1'b0;
                  end else begin
                     slice_in = slice_next[COUNT_W-1:0];
                  end
               end else begin
                  stack_in  = stack_next[COUNT_W-1:0];
                  phi_q_in  = ph_adv[WORD_W+COUNT_W-1:COUNT_W];
                  phi_r_in  = ph_adv[COUNT_W-1:0];
                  text_q_in = tt_adv[COUNT_W+HALF_W-1:COUNT_W];
                  text_r_in = tt_adv[COUNT_W-1:0];
               end
            end
            PHASE_TRIANGLE: begin
               if (middle && !second_ff) begin
                  second_in = 1'b1;
               end else begin
                  second_in = 1'b0;
                  if (stack_next >= {1'b0, t_cnt}) begin
                     stack_in = '0;
                     base_in  = base_ff + row_len;
                     if (slice_next >= {1'b0, s_cnt}) begin
                        slice_in = '0;
                        phase_in = PHASE_DONE;
                     end else begin
                        slice_in = slice_next[COUNT_W-1:0];
                     end
                  end else begin
                     stack_in = stack_next[COUNT_W-1:0];
                  end
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_VERTEX;
         slice_ff  <= '0;
         stack_ff  <= '0;
         second_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         slice_ff  <= slice_in;
         stack_ff  <= stack_in;
         second_ff <= second_in;
      end
      theta_q_ff <= theta_q_in;
      theta_r_ff <= theta_r_in;
      phi_q_ff   <= phi_q_in;
      phi_r_ff   <= phi_r_in;
      texs_q_ff  <= texs_q_in;
      texs_r_ff  <= texs_r_in;
      text_q_ff  <= text_q_in;
      text_r_ff  <= text_r_in;
      base_ff    <= base_in;
   end

   assign status.vertex_phase = (phase_ff == PHASE_VERTEX);

   // ---------------------------------------------------------------
   // CORDIC unit, one rotation a cycle, shared by the two angles.
   logic signed [33:0]       cx_ff, cy_ff;
   logic signed [32:0]       cz_ff;
   logic [1:0]               quad_ff;
   logic [K_W-1:0]           kstep_ff;
   logic [WORD_W-1:0]        turn;
   logic signed [33:0]       dx, dy;
   logic signed [32:0]       atan_k;
   logic signed [WORD_W-1:0] map_c, map_s;
   logic signed [WORD_W-1:0] ct_ff, st_ff, cp_ff, sp_ff;

   assign turn   = cmd.cordic_sel_phi ? phi_q_ff : theta_q_ff;
   assign dx     = cy_ff >>> kstep_ff;
   assign dy     = cx_ff >>> kstep_ff;
   assign atan_k = $signed({1'b0, atan_turn(5'(kstep_ff))});

   always_ff @(posedge clock) begin
      if (cmd.cordic_load) begin
         cx_ff    <= CORDIC_GAIN;
         cy_ff    <= '0;
         cz_ff    <= $signed({3'b000, turn[29:0]});
         quad_ff  <= turn[31:30];
         kstep_ff <= '0;
      end else if (cmd.cordic_step) begin
         if (!cz_ff[32]) begin
            cx_ff <= cx_ff - dx;
            cy_ff <= cy_ff + dy;
            cz_ff <= cz_ff - atan_k;
         end else begin
            cx_ff <= cx_ff + dx;
            cy_ff <= cy_ff - dy;
            cz_ff <= cz_ff + atan_k;
         end
         kstep_ff <= kstep_ff + K_W'(1);
      end
   end

   assign status.cordic_last = (kstep_ff == K_W'(TRIG_STEPS - 1));

   // Quadrant fold of the rotated vector.
   always_comb begin
      case (quad_ff)
         2'd0: begin
            map_c = WORD_W'(cx_ff);
            map_s = WORD_W'(cy_ff);
         end
         2'd1: begin
            map_c = WORD_W'(-cy_ff);
            map_s = WORD_W'(cx_ff);
         end
         2'd2: begin
            map_c = WORD_W'(-cx_ff);
            map_s = WORD_W'(-cy_ff);
         end
         default: begin
            map_c = WORD_W'(cy_ff);
            map_s = WORD_W'(-cx_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.save_theta) begin
         ct_ff <= map_c;
         st_ff <= map_s;
      end
      if (cmd.save_phi) begin
         cp_ff <= map_c;
         sp_ff <= map_s;
      end
   end

   // ---------------------------------------------------------------
   // Shared multiplier: one product a cycle, rounded and written back in the next cycle.
   logic [2:0]               mul_cnt_ff;
   logic                     wb_valid_ff;
   logic [2:0]               wb_tag_ff;
   logic signed [65:0]       product_ff;
   logic signed [32:0]       mul_a, mul_b;
   logic signed [65:0]       prod_round;
   logic signed [32:0]       radius_s;
   logic signed [WORD_W-1:0] nx_ff, ny_ff, px_ff, py_ff, pz_ff;

   assign radius_s = $signed({9'b0, radius_ff});

   always_comb begin
      case (mul_cnt_ff)
         MUL_NX: begin
            mul_a = 33'(sp_ff);
            mul_b = 33'(ct_ff);
         end
         MUL_NY: begin
            mul_a = 33'(sp_ff);
            mul_b = 33'(st_ff);
         end
         MUL_PX: begin
            mul_a = radius_s;
            mul_b = 33'(nx_ff);
         end
         MUL_PY: begin
            mul_a = radius_s;
            mul_b = 33'(ny_ff);
         end
         MUL_PZ: begin
            mul_a = radius_s;
            mul_b = 33'(cp_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_round = (product_ff + (66'sd1 <<< 29)) >>> 30;

   always_ff @(posedge clock) begin
      if (cmd.mul_init) begin
         mul_cnt_ff  <= MUL_NX;
         wb_valid_ff <= 1'b0;
      end else if (cmd.mul_run) begin
         if (mul_cnt_ff != MUL_DONE) begin
            product_ff  <= mul_a * mul_b;
            wb_tag_ff   <= mul_cnt_ff;
            wb_valid_ff <= 1'b1;
            mul_cnt_ff  <= mul_cnt_ff + 3'd1;
         end else begin
            wb_valid_ff <= 1'b0;
         end
      end
      if (wb_valid_ff) begin
         case (wb_tag_ff)
            MUL_NX:  nx_ff <= prod_round[WORD_W-1:0];
            MUL_NY:  ny_ff <= prod_round[WORD_W-1:0];
            MUL_PX:  px_ff <= prod_round[WORD_W-1:0];
            MUL_PY:  py_ff <= prod_round[WORD_W-1:0];
            default: pz_ff <= prod_round[WORD_W-1:0];
         endcase
      end
   end

   assign status.mul_last = (mul_cnt_ff == MUL_DONE);

   // ---------------------------------------------------------------
   // Result formation and output register.
   rsp_payload_type     result;
   rsp_payload_type     rsp_ff;
   logic                rsp_valid_ff;
   logic [INDEX_W-1:0]  next_row;
   logic [INDEX_W-1:0]  j_ext;
   logic [INDEX_W-1:0]  ia, ib, ic;

   assign next_row = base_ff + row_len;
   assign j_ext    = INDEX_W'(stack_ff);

   always_comb begin
      if (stack_ff == '0) begin
         ia = base_ff;
         ib = base_ff + INDEX_W'(1);
         ic = next_row + INDEX_W'(1);
      end else if (stack_ff == t_cnt - COUNT_W'(1)) begin
         ia = base_ff + j_ext;
         ib = base_ff + j_ext + INDEX_W'(1);
         ic = next_row + j_ext;
      end else if (!second_ff) begin
         ia = base_ff + j_ext;
         ib = base_ff + j_ext + INDEX_W'(1);
         ic = next_row + j_ext + INDEX_W'(1);
      end else begin
         ia = next_row + j_ext;
         ib = base_ff + j_ext;
         ic = next_row + j_ext + INDEX_W'(1);
      end
   end

   always_comb begin
      result = '0;
      case (phase_ff)
         PHASE_VERTEX: begin
            result.kind     = KIND_VERTEX;
            result.word_a   = px_ff;
            result.word_b   = py_ff;
            result.word_c   = pz_ff;
            result.normal_x = q15_sat(nx_ff);
            result.normal_y = q15_sat(ny_ff);
            result.normal_z = q15_sat(cp_ff);
            result.tex_s    = texs_q_ff;
            result.tex_t    = text_q_ff;
         end
         PHASE_TRIANGLE: begin
            result.kind   = KIND_TRIANGLE;
            result.word_a = $signed(WORD_W'(ia));
            result.word_b = $signed(WORD_W'(ib));
            result.word_c = $signed(WORD_W'(ic));
            result.last   = (slice_ff == s_cnt - COUNT_W'(1)) &&
                            (stack_ff == t_cnt - COUNT_W'(1));
         end
         default: result.kind = KIND_FINISHED;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_ff <= result;
      end
   end

   assign status.rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule

// ===== rtl/uv_sphere_mesh_generator_top.sv =====
// Top level of the UV sphere mesh generator: controller plus datapath.
// Depends on usmg_pkg, usmg_stream_if, usmg_ctrl, usmg_dp and assert_macros.svh.
//
//   Port       Direction  Transaction
//   req_chan   sink       one step request: restart flag
//   rsp_chan   source     one mesh item: vertex, triangle or finished marker
//   csr_*      input      register write: radius, slice count, stack count
//
// A vertex's time is set by the one shared CORDIC unit running the slice
// angle and then the stack angle, followed by five products through one
// multiplier. Triangle and finished items skip those passes. After reset
// and after each register write, a divider pass builds the angle steps;
// no request is taken meanwhile.
// A request is taken while the previous result still waits on rsp_chan; the
// new result waits until that one is taken.
`include "assert_macros.svh"

module uv_sphere_mesh_generator_top #(
   parameter int MAX_DIVISIONS = usmg_pkg::MAX_DIVISIONS_DEFAULT,
   parameter int TRIG_STEPS    = usmg_pkg::TRIG_STEPS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   usmg_stream_if.sink                         req_chan,
   usmg_stream_if.source                       rsp_chan,
   input  logic                                csr_write_en,
   input  logic [usmg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [usmg_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import usmg_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       csr_hit;

   usmg_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_restart  (req_chan.payload.restart),
      .req_ready    (req_chan.ready),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .status       (status),
      .cmd          (cmd)
   );

   usmg_dp #(
      .MAX_DIVISIONS (MAX_DIVISIONS),
      .TRIG_STEPS    (TRIG_STEPS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status),
      .rsp_chan     (rsp_chan)
   );

   // Write to one of the listed registers.
   assign csr_hit = csr_write_en &&
                    (csr_index == CSR_RADIUS || csr_index == CSR_SLICES ||
                     csr_index == CSR_STACKS);

   // A known register write starts the divider pass, which blocks requests.
   `USMG_ASSERT_NEXT(a_csr_blocks_req, clock, reset, csr_hit, !req_chan.ready, "request taken during setup")

   // Only one request is in work at a time.
   `USMG_ASSERT_NEXT(a_one_in_flight, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready, "second request taken while busy")

   // A result is only loaded when the output register is free.
   `USMG_ASSERT_IMPL(a_emit_free, clock, reset, cmd.emit, status.rsp_free, "result overwrote a pending transaction")

   // Loading a result presents it on the next cycle.
   `USMG_ASSERT_NEXT(a_emit_shows, clock, reset, cmd.emit, rsp_chan.valid, "loaded result not presented")

endmodule
